@@ rtl/sdflpb_pkg.sv @@
// ----------------------------------------------------------------------------
// sdflpb_pkg
// shared register indexes and pipeline helpers for the line pixel blender
// ----------------------------------------------------------------------------
package sdflpb_pkg;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FLIP   = 2'd2;

    localparam int DIM_BITS  = 13;
    localparam int RGB_BITS  = 24;
    localparam int COV_BITS  = 9;
    localparam int IDX_BITS  = 24;

    typedef struct packed {
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
        logic                flip;
    } cfg_t;

    typedef struct packed {
        logic                write_ok;
        logic [IDX_BITS-1:0] pixel_index;
    } addr_t;

endpackage

@@ rtl/sdf_line_pixel_blend_top.sv @@
// ----------------------------------------------------------------------------
// sdf_line_pixel_blend_top
// anti-aliased capsule line shader with per-byte alpha blend
// ----------------------------------------------------------------------------
// Accepts one pixel beat per clock and returns one result beat per pixel in
// order. The pipeline has 3*COORD_BITS+45 register stages (84 for 13-bit
// coordinates): four front stages for differences, products, sums and path
// select, one stage per bit of the 2*COORD_BITS+25 bit cross^2/len2 quotient,
// one register ahead of the square root, one stage per root bit
// (COORD_BITS+13), then an alpha stage and a blend stage. Every stage advances
// together when the output register is free or taken, so the sustained rate
// is one pixel per clock.
module sdf_line_pixel_blend_top #(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pixel_x, pixel_y, start_x, start_y, end_x, end_y, radius, line_rgb, old_rgb
    input  logic [((6*COORD_BITS+12+48)+7)/8*8-1:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // write_ok, pixel_index, new_rgb, coverage
    output logic [63:0]  m_axis_tdata
);

    localparam int CB   = COORD_BITS;
    localparam int DFB  = CB + 1;                 // difference width
    localparam int L2B  = 2*DFB + 1;              // len2 / dot width
    localparam int CRB  = 2*DFB + 1;              // |cross| width
    localparam int NB   = 2*CRB + 24;             // numerator width
    localparam int QB   = 2*DFB - 1 + 24;         // quotient width
    localparam int VB   = ((QB + 1) / 2) * 2;
    localparam int RB   = VB / 2;
    localparam int PB   = 1 + 12 + 48;            // valid, radius, colors
    localparam int DLY  = QB + RB + 4;

    sdflpb_pkg::cfg_t cfg_reg;
    logic             wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= 13'd640;
            cfg_reg.height <= 13'd480;
            cfg_reg.flip   <= 1'b0;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                sdflpb_pkg::REG_WIDTH:  cfg_reg.width  <= pwdata[12:0];
                sdflpb_pkg::REG_HEIGHT: cfg_reg.height <= pwdata[12:0];
                sdflpb_pkg::REG_FLIP:   cfg_reg.flip   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            sdflpb_pkg::REG_WIDTH:  prdata = 32'(cfg_reg.width);
            sdflpb_pkg::REG_HEIGHT: prdata = 32'(cfg_reg.height);
            sdflpb_pkg::REG_FLIP:   prdata = 32'(cfg_reg.flip);
            default:                prdata = '0;
        endcase
    end

    // global stall: every stage moves when the output register can take data
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [CB-1:0] px, py, ax, ay, bx, by;
    logic [11:0]          rad;
    logic [23:0]          lrgb, orgb;
    logic                 vin;
    always_comb
    begin
        px   = s_axis_tdata[0*CB +: CB];
        py   = s_axis_tdata[1*CB +: CB];
        ax   = s_axis_tdata[2*CB +: CB];
        ay   = s_axis_tdata[3*CB +: CB];
        bx   = s_axis_tdata[4*CB +: CB];
        by   = s_axis_tdata[5*CB +: CB];
        rad  = s_axis_tdata[6*CB +: 12];
        lrgb = s_axis_tdata[6*CB+12 +: 24];
        orgb = s_axis_tdata[6*CB+36 +: 24];
        vin  = s_axis_tvalid;
    end

    // stage 1: differences
    logic signed [DFB-1:0] pax_reg, pay_reg, bax_reg, bay_reg, qx_reg, qy_reg;
    logic [PB-1:0]         p1_reg;
    // stage 2: products
    logic signed [2*DFB-1:0] m_pp_reg [6];
    logic signed [2*DFB-1:0] c1_reg, c2_reg;
    logic [PB-1:0]         p2_reg;
    // stage 3: sums
    logic signed [L2B-1:0] len2_reg, dot_reg;
    logic [L2B-1:0]        da_reg, db_reg;
    logic [CRB-1:0]        cr_reg;
    logic [PB-1:0]         p3_reg;
    // stage 4: pick path
    logic [NB-1:0]         num_reg;
    logic [L2B-1:0]        den_reg;
    logic                  direct_reg;
    logic [L2B-1:0]        dsq_reg;
    logic [PB-1:0]         p4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg[0] <= 1'b0;
            p2_reg[0] <= 1'b0;
            p3_reg[0] <= 1'b0;
            p4_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            p1_reg  <= {orgb, lrgb, rad, vin};
            pax_reg <= DFB'(px) - DFB'(ax);
            pay_reg <= DFB'(py) - DFB'(ay);
            bax_reg <= DFB'(bx) - DFB'(ax);
            bay_reg <= DFB'(by) - DFB'(ay);
            qx_reg  <= DFB'(px) - DFB'(bx);
            qy_reg  <= DFB'(py) - DFB'(by);

            p2_reg      <= p1_reg;
            m_pp_reg[0] <= bax_reg * bax_reg;
            m_pp_reg[1] <= bay_reg * bay_reg;
            m_pp_reg[2] <= pax_reg * bax_reg;
            m_pp_reg[3] <= pay_reg * bay_reg;
            m_pp_reg[4] <= pax_reg * pax_reg + pay_reg * pay_reg;
            m_pp_reg[5] <= qx_reg * qx_reg + qy_reg * qy_reg;
            c1_reg      <= pax_reg * bay_reg;
            c2_reg      <= pay_reg * bax_reg;

            p3_reg   <= p2_reg;
            len2_reg <= L2B'(m_pp_reg[0]) + L2B'(m_pp_reg[1]);
            dot_reg  <= L2B'(m_pp_reg[2]) + L2B'(m_pp_reg[3]);
            da_reg   <= L2B'(unsigned'(m_pp_reg[4]));
            db_reg   <= L2B'(unsigned'(m_pp_reg[5]));
            cr_reg   <= (L2B'(c1_reg) - L2B'(c2_reg)) < 0
                        ? CRB'(L2B'(c2_reg) - L2B'(c1_reg))
                        : CRB'(L2B'(c1_reg) - L2B'(c2_reg));

            p4_reg <= p3_reg;
            num_reg <= NB'(cr_reg * cr_reg) << 24;
            den_reg <= (len2_reg == 0) ? L2B'(1) : L2B'(len2_reg);
            if (len2_reg == 0 || dot_reg <= 0)
            begin
                direct_reg <= 1'b1;
                dsq_reg    <= da_reg;
            end
            else if (dot_reg >= len2_reg)
            begin
                direct_reg <= 1'b1;
                dsq_reg    <= db_reg;
            end
            else
            begin
                direct_reg <= 1'b0;
                dsq_reg    <= da_reg;
            end
        end
    end

    // divider, with direct path riding alongside
    localparam int DPB = PB + 1 + L2B;
    logic [QB-1:0]  quo;
    logic [DPB-1:0] dpass;
    sdflpb_div #(.NB(NB), .DB(L2B), .QB(QB), .PB(DPB)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .num      (num_reg),
        .den      (den_reg),
        .pass_in  ({dsq_reg, direct_reg, p4_reg}),
        .quo      (quo),
        .pass_out (dpass)
    );

    logic [VB-1:0] d2_reg;
    logic [PB-1:0] p5_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p5_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            p5_reg <= dpass[PB-1:0];
            d2_reg <= dpass[PB] ? (VB'(dpass[DPB-1 -: L2B]) << 24) : VB'(quo);
        end
    end

    logic [RB-1:0] root_dist;
    logic [PB-1:0] p6;
    sdflpb_isqrt #(.VB(VB), .RB(RB), .PB(PB)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .val      (d2_reg),
        .pass_in  (p5_reg),
        .root     (root_dist),
        .pass_out (p6)
    );

    // alpha
    logic [8:0]   cov_reg;
    logic [PB-1:0] p7_reg;
    logic signed [RB+2:0] alpha;
    always_comb
    begin
        alpha = (RB+3)'(2048)
              + (RB+3)'({p6[12:1], {(12-FRAC_BITS){1'b0}}} >> 0)
              - (RB+3)'(root_dist);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p7_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            p7_reg <= p6;
            if (alpha < 0)
                cov_reg <= '0;
            else if (alpha > 4096)
                cov_reg <= 9'd256;
            else
                cov_reg <= 9'(alpha >>> 4);
        end
    end

    // blend
    logic [23:0] rgb;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rgb[8*k +: 8] = 8'((17'(p7_reg[37+8*k +: 8]) * 17'(9'd256 - cov_reg)
                            + 17'(p7_reg[13+8*k +: 8]) * 17'(cov_reg)) >> 8);
        end
    end

    // address path delayed to line up with blend output
    sdflpb_pkg::addr_t addr;
    logic signed [CB-1:0] ax_reg [DLY+1];
    logic signed [CB-1:0] ay_reg [DLY+1];
    always_comb
    begin
        ax_reg[0] = px;
        ay_reg[0] = py;
    end
    for (genvar s = 0; s < DLY; s++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ax_reg[s+1] <= ax_reg[s];
                ay_reg[s+1] <= ay_reg[s];
            end
        end
    end

    sdflpb_addr #(.CB(CB)) u_addr (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .cfg   (cfg_reg),
        .px    (ax_reg[DLY]),
        .py    (ay_reg[DLY]),
        .addr  (addr)
    );

    logic        v8_reg;
    logic [32:0] rc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v8_reg <= p7_reg[0];
            rc_reg <= {cov_reg, rgb};
        end
    end

    assign m_axis_tvalid = v8_reg;
    assign m_axis_tdata  = {6'b0, rc_reg[32:24], rc_reg[23:0],
                            addr.pixel_index, addr.write_ok};

endmodule

@@ rtl/sdflpb_addr.sv @@
// ----------------------------------------------------------------------------
// sdflpb_addr
// bounds check, optional row flip and framebuffer index, three stages
// ----------------------------------------------------------------------------
module sdflpb_addr #(
    parameter int CB = 13
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  sdflpb_pkg::cfg_t        cfg,
    input  logic signed [CB-1:0]    px,
    input  logic signed [CB-1:0]    py,
    output sdflpb_pkg::addr_t       addr
);

    localparam int DB = sdflpb_pkg::DIM_BITS;
    localparam int IB = sdflpb_pkg::IDX_BITS;
    localparam int XB = (CB > DB) ? CB : DB;

    logic            ok_a_reg;
    logic [DB-1:0]   row_a_reg;
    logic [DB-1:0]   col_a_reg;
    logic            ok_b_reg;
    logic [2*DB-1:0] prod_b_reg;
    logic [DB-1:0]   col_b_reg;
    logic [XB:0]     pxe;
    logic [XB:0]     pye;
    logic            ok_next;
    logic [DB-1:0]   row_next;
    logic [2*DB:0]   sum;

    always_comb
    begin
        pxe = (XB+1)'(unsigned'(px));
        pye = (XB+1)'(unsigned'(py));
        ok_next = !px[CB-1] && !py[CB-1]
            && (pxe < (XB+1)'(cfg.width)) && (pye < (XB+1)'(cfg.height));
        row_next = cfg.flip ? DB'(cfg.height - DB'(1) - DB'(pye)) : DB'(pye);
        sum = (2*DB+1)'(prod_b_reg) + (2*DB+1)'(col_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr <= '0;
        end
        else if (en)
        begin
            ok_a_reg   <= ok_next;
            row_a_reg  <= row_next;
            col_a_reg  <= DB'(pxe);
            ok_b_reg   <= ok_a_reg;
            prod_b_reg <= row_a_reg * cfg.width;
            col_b_reg  <= col_a_reg;
            addr.write_ok    <= ok_b_reg;
            addr.pixel_index <= ok_b_reg ? IB'(sum) : '0;
        end
    end

endmodule

@@ rtl/sdflpb_isqrt.sv @@
// ----------------------------------------------------------------------------
// sdflpb_isqrt
// pipelined restoring square root, one result bit per stage, 2 bits a stage
// ----------------------------------------------------------------------------
module sdflpb_isqrt #(
    parameter int VB = 64,
    parameter int RB = 32,
    parameter int PB = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [VB-1:0] val,
    input  logic [PB-1:0] pass_in,
    output logic [RB-1:0] root,
    output logic [PB-1:0] pass_out
);

    logic [VB-1:0]   v_reg [RB+1];
    logic [RB+1:0]   r_reg [RB+1];
    logic [RB-1:0]   q_reg [RB+1];
    logic [PB-1:0]   p_reg [RB+1];

    always_comb
    begin
        v_reg[0] = val;
        r_reg[0] = '0;
        q_reg[0] = '0;
        p_reg[0] = pass_in;
    end

    for (genvar s = 0; s < RB; s++)
    begin : g_st
        logic [RB+1:0] rem;
        logic [RB+1:0] trial;
        always_comb
        begin
            rem   = {r_reg[s][RB-1:0], v_reg[s][VB-1 -: 2]};
            trial = {q_reg[s], 2'b01};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                p_reg[s+1] <= '0;
            end
            else if (en)
            begin
                p_reg[s+1] <= p_reg[s];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[s+1] <= v_reg[s] << 2;
                if (rem >= trial)
                begin
                    r_reg[s+1] <= rem - trial;
                    q_reg[s+1] <= {q_reg[s][RB-2:0], 1'b1};
                end
                else
                begin
                    r_reg[s+1] <= rem;
                    q_reg[s+1] <= {q_reg[s][RB-2:0], 1'b0};
                end
            end
        end
    end

    assign root     = q_reg[RB];
    assign pass_out = p_reg[RB];

endmodule

@@ rtl/sdflpb_div.sv @@
// ----------------------------------------------------------------------------
// sdflpb_div
// pipelined restoring divider for cross^2*2^24 / len2, one quotient bit a stage
// ----------------------------------------------------------------------------
module sdflpb_div #(
    parameter int NB = 84,
    parameter int DB = 28,
    parameter int QB = 60,
    parameter int PB = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [NB-1:0] num,
    input  logic [DB-1:0] den,
    input  logic [PB-1:0] pass_in,
    output logic [QB-1:0] quo,
    output logic [PB-1:0] pass_out
);

    // quotient bits above QB are zero by range, so the top NB-QB numerator
    // bits seed the remainder directly
    localparam int SB = NB - QB;

    logic [NB-1:0] n_reg [QB+1];
    logic [DB:0]   r_reg [QB+1];
    logic [DB-1:0] d_reg [QB+1];
    logic [QB-1:0] q_reg [QB+1];
    logic [PB-1:0] p_reg [QB+1];

    always_comb
    begin
        n_reg[0] = num << SB;
        r_reg[0] = (DB+1)'(num[NB-1 -: SB]);
        d_reg[0] = den;
        q_reg[0] = '0;
        p_reg[0] = pass_in;
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_st
        logic [DB+1:0] rem;
        always_comb
        begin
            rem = {r_reg[s], n_reg[s][NB-1]};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                p_reg[s+1] <= '0;
            end
            else if (en)
            begin
                p_reg[s+1] <= p_reg[s];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s+1] <= n_reg[s] << 1;
                d_reg[s+1] <= d_reg[s];
                if (rem >= (DB+2)'(d_reg[s]))
                begin
                    r_reg[s+1] <= (DB+1)'(rem - (DB+2)'(d_reg[s]));
                    q_reg[s+1] <= {q_reg[s][QB-2:0], 1'b1};
                end
                else
                begin
                    r_reg[s+1] <= (DB+1)'(rem);
                    q_reg[s+1] <= {q_reg[s][QB-2:0], 1'b0};
                end
            end
        end
    end

    assign quo      = q_reg[QB];
    assign pass_out = p_reg[QB];

endmodule
